>>> hdl/ete_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the expression tokenizer.
// Holds the token kind codes, the result token record and the result queue sizing.
package ete_pkg;

    localparam logic [4:0] KIND_BAD        = 5'd0;
    localparam logic [4:0] KIND_EOF        = 5'd1;
    localparam logic [4:0] KIND_NUMBER     = 5'd2;
    localparam logic [4:0] KIND_WORD       = 5'd3;
    localparam logic [4:0] KIND_SPACE      = 5'd4;
    localparam logic [4:0] KIND_PLUS       = 5'd5;
    localparam logic [4:0] KIND_MINUS      = 5'd6;
    localparam logic [4:0] KIND_STAR       = 5'd7;
    localparam logic [4:0] KIND_SLASH      = 5'd8;
    localparam logic [4:0] KIND_TILDE      = 5'd9;
    localparam logic [4:0] KIND_CARET      = 5'd10;
    localparam logic [4:0] KIND_EQ_EQ      = 5'd11;
    localparam logic [4:0] KIND_EQ         = 5'd12;
    localparam logic [4:0] KIND_NOT_EQ     = 5'd13;
    localparam logic [4:0] KIND_BANG       = 5'd14;
    localparam logic [4:0] KIND_LESS_EQ    = 5'd15;
    localparam logic [4:0] KIND_LESS       = 5'd16;
    localparam logic [4:0] KIND_GREATER_EQ = 5'd17;
    localparam logic [4:0] KIND_GREATER    = 5'd18;
    localparam logic [4:0] KIND_AND_AND    = 5'd19;
    localparam logic [4:0] KIND_AMP        = 5'd20;
    localparam logic [4:0] KIND_OR_OR      = 5'd21;
    localparam logic [4:0] KIND_BAR        = 5'd22;
    localparam logic [4:0] KIND_LPAREN     = 5'd23;
    localparam logic [4:0] KIND_RPAREN     = 5'd24;
    localparam logic [4:0] KIND_LBRACE     = 5'd25;
    localparam logic [4:0] KIND_RBRACE     = 5'd26;
    localparam logic [4:0] KIND_LAST       = KIND_RBRACE;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [30:0] value;
        logic        overflow;
        logic        last;
    } t_token;

endpackage

>>> hdl/ete_scan.sv
`timescale 1ns / 1ps
// Scanner core: holds the run and lookahead state and decodes one byte per cycle while i_fire is high.
// Produces up to two result tokens per item. Depends on ete_pkg.
module ete_scan #(
    parameter int POSITION_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_char,
    input  logic            i_eot,
    output ete_pkg::t_token o_tok0,
    output ete_pkg::t_token o_tok1,
    output logic [1:0]      o_count
);
    import ete_pkg::*;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_SPACE
    } t_class;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_EQ,
        PEND_BANG,
        PEND_LESS,
        PEND_GREATER,
        PEND_AMP,
        PEND_BAR
    } t_pend;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_class                   r_class,     n_class;
    t_pend                    r_pend,      n_pend;
    logic [POSITION_BITS-1:0] r_run_start, n_run_start;
    logic [POSITION_BITS-1:0] r_pos,       n_pos;
    logic [30:0]              r_acc,       n_acc;
    logic                     r_ovf,       n_ovf;

    t_class      cls;
    t_pend       op_pend;
    logic [4:0]  op_kind;
    logic [4:0]  single_kind;
    logic [4:0]  pair_kind;
    logic        pair;
    logic [31:0] ext_start;
    logic [31:0] ext_pos;
    logic [31:0] ext_len;
    logic [15:0] start16;
    logic [15:0] pos16;
    logic [15:0] len16;
    logic [30:0] digit;
    logic [34:0] prod;
    t_token      fl;
    t_token      single_tok;
    t_token      eof_tok;

    always_comb begin
        case (i_char) inside
            [8'h30:8'h39]:               cls = CLS_DIGIT;
            [8'h41:8'h5A], [8'h61:8'h7A]: cls = CLS_LETTER;
            [8'h09:8'h0D], 8'h20:        cls = CLS_SPACE;
            default:                     cls = CLS_NONE;
        endcase
    end

    always_comb begin
        op_pend = PEND_NONE;
        op_kind = KIND_BAD;
        case (i_char)
            8'h2B:   op_kind = KIND_PLUS;
            8'h2D:   op_kind = KIND_MINUS;
            8'h2A:   op_kind = KIND_STAR;
            8'h2F:   op_kind = KIND_SLASH;
            8'h7E:   op_kind = KIND_TILDE;
            8'h5E:   op_kind = KIND_CARET;
            8'h28:   op_kind = KIND_LPAREN;
            8'h29:   op_kind = KIND_RPAREN;
            8'h7B:   op_kind = KIND_LBRACE;
            8'h7D:   op_kind = KIND_RBRACE;
            8'h3D:   op_pend = PEND_EQ;
            8'h21:   op_pend = PEND_BANG;
            8'h3C:   op_pend = PEND_LESS;
            8'h3E:   op_pend = PEND_GREATER;
            8'h26:   op_pend = PEND_AMP;
            8'h7C:   op_pend = PEND_BAR;
            default: op_kind = KIND_BAD;
        endcase
    end

    always_comb begin
        case (r_pend)
            PEND_EQ: begin
                single_kind = KIND_EQ;
                pair_kind   = KIND_EQ_EQ;
                pair        = (i_char == 8'h3D);
            end
            PEND_BANG: begin
                single_kind = KIND_BANG;
                pair_kind   = KIND_NOT_EQ;
                pair        = (i_char == 8'h3D);
            end
            PEND_LESS: begin
                single_kind = KIND_LESS;
                pair_kind   = KIND_LESS_EQ;
                pair        = (i_char == 8'h3D);
            end
            PEND_GREATER: begin
                single_kind = KIND_GREATER;
                pair_kind   = KIND_GREATER_EQ;
                pair        = (i_char == 8'h3D);
            end
            PEND_AMP: begin
                single_kind = KIND_AMP;
                pair_kind   = KIND_AND_AND;
                pair        = (i_char == 8'h26);
            end
            PEND_BAR: begin
                single_kind = KIND_BAR;
                pair_kind   = KIND_OR_OR;
                pair        = (i_char == 8'h7C);
            end
            default: begin
                single_kind = KIND_BAD;
                pair_kind   = KIND_BAD;
                pair        = 1'b0;
            end
        endcase
    end

    // Positions and lengths are reported clipped to 16 bits.
    always_comb begin
        ext_start = 32'(r_run_start);
        ext_pos   = 32'(r_pos);
        ext_len   = 32'(r_pos - r_run_start);
        start16   = (|ext_start[31:16]) ? 16'hFFFF : ext_start[15:0];
        pos16     = (|ext_pos[31:16])   ? 16'hFFFF : ext_pos[15:0];
        len16     = (|ext_len[31:16])   ? 16'hFFFF : ext_len[15:0];
        digit     = {27'd0, i_char[3:0]};
        prod      = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {4'd0, digit};
    end

    always_comb begin
        fl       = '0;
        fl.start = start16;
        if (r_pend != PEND_NONE) begin
            fl.kind   = single_kind;
            fl.length = 16'd1;
        end else begin
            fl.length = len16;
            case (r_class)
                CLS_DIGIT: begin
                    fl.kind     = KIND_NUMBER;
                    fl.value    = r_acc;
                    fl.overflow = r_ovf;
                end
                CLS_LETTER: fl.kind = KIND_WORD;
                default:    fl.kind = KIND_SPACE;
            endcase
        end
        single_tok        = '0;
        single_tok.kind   = op_kind;
        single_tok.start  = pos16;
        single_tok.length = 16'd1;
        eof_tok           = '0;
        eof_tok.kind      = KIND_EOF;
        eof_tok.start     = pos16;
    end

    always_comb begin
        n_class     = r_class;
        n_pend      = r_pend;
        n_run_start = r_run_start;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        o_tok0      = '0;
        o_tok1      = '0;
        o_count     = 2'd0;
        if (i_fire) begin
            if (i_eot) begin
                if (r_pend != PEND_NONE || r_class != CLS_NONE) begin
                    o_tok0  = fl;
                    o_tok1  = eof_tok;
                    o_count = 2'd2;
                end else begin
                    o_tok0  = eof_tok;
                    o_count = 2'd1;
                end
                n_class     = CLS_NONE;
                n_pend      = PEND_NONE;
                n_run_start = '0;
                n_pos       = '0;
                n_acc       = '0;
                n_ovf       = 1'b0;
            end else begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + POSITION_BITS'(1);
                end
                if (r_pend != PEND_NONE && pair) begin
                    o_tok0        = fl;
                    o_tok0.kind   = pair_kind;
                    o_tok0.length = 16'd2;
                    o_count       = 2'd1;
                    n_pend        = PEND_NONE;
                end else if (r_pend == PEND_NONE && r_class != CLS_NONE && cls == r_class) begin
                    if (r_class == CLS_DIGIT) begin
                        if (prod > {4'd0, VALUE_MAX}) begin
                            n_acc = VALUE_MAX;
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[30:0];
                        end
                    end
                end else begin
                    if (r_pend != PEND_NONE || r_class != CLS_NONE) begin
                        o_tok0  = fl;
                        o_count = 2'd1;
                    end
                    n_pend  = PEND_NONE;
                    n_class = CLS_NONE;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    if (cls != CLS_NONE) begin
                        n_class     = cls;
                        n_run_start = r_pos;
                        n_acc       = (cls == CLS_DIGIT) ? digit : '0;
                    end else if (op_pend != PEND_NONE) begin
                        n_pend      = op_pend;
                        n_run_start = r_pos;
                    end else if (o_count == 2'd0) begin
                        o_tok0  = single_tok;
                        o_count = 2'd1;
                    end else begin
                        o_tok1  = single_tok;
                        o_count = 2'd2;
                    end
                end
            end
            if (o_count == 2'd1) begin
                o_tok0.last = 1'b1;
            end
            if (o_count == 2'd2) begin
                o_tok1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class     <= CLS_NONE;
            r_pend      <= PEND_NONE;
            r_run_start <= '0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_class     <= n_class;
            r_pend      <= n_pend;
            r_run_start <= n_run_start;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
        end
    end

endmodule

>>> hdl/ete_queue.sv
`timescale 1ns / 1ps
// Result queue: takes zero, one or two tokens per cycle and presents one per cycle while i_pop takes them.
// Keeps the output side apart from the scanner. Depends on ete_pkg.
module ete_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_count,
    input  ete_pkg::t_token i_tok0,
    input  ete_pkg::t_token i_tok1,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output ete_pkg::t_token o_head
);
    import ete_pkg::*;

    t_token                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr, n_wr;
    logic [QUEUE_PTR_BITS-1:0] r_rd, n_rd;
    logic [QUEUE_CNT_BITS-1:0] r_count, n_count;
    logic                      pop_fire;

    assign pop_fire = i_pop && (r_count != '0);
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd];
    assign o_room   = (r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + QUEUE_PTR_BITS'(i_push_count);
        n_rd    = r_rd + QUEUE_PTR_BITS'(pop_fire);
        n_count = r_count + QUEUE_CNT_BITS'(i_push_count) - QUEUE_CNT_BITS'(pop_fire);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + QUEUE_PTR_BITS'(1)] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/expression_tokenizer.sv
`timescale 1ns / 1ps
// Expression tokenizer top level: input register, scanner core and result queue.
// An accepted byte is registered at the input; its tokens are registered in the result queue.
// Throughput: one byte per cycle while the queue has room; two tokens of one item leave in turn.
// The four-entry result queue admits a new item only while two entries are free.
// Reset (synchronous, active low) clears the scanner state, position and queue.
// Depends on ete_pkg, ete_scan and ete_queue.
module expression_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  logic        s_axis_tlast,  // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [15:0] token_start, [31:16] token_length,
                                       // [62:32] number_value, [63] number_overflow
    output logic [4:0]  m_axis_tuser,  // [4:0] token_kind
    output logic        m_axis_tlast   // last_of_item
);
    import ete_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eot;
    logic       scan_fire;
    logic       room;
    logic [1:0] push_count;
    t_token     tok0;
    t_token     tok1;
    t_token     head;

    assign scan_fire     = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || scan_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    ete_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (scan_fire),
        .i_char  (r_in_char),
        .i_eot   (r_in_eot),
        .o_tok0  (tok0),
        .o_tok1  (tok1),
        .o_count (push_count)
    );

    ete_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_tok0       (tok0),
        .i_tok1       (tok1),
        .i_pop        (m_axis_tready),
        .o_room       (room),
        .o_valid      (m_axis_tvalid),
        .o_head       (head)
    );

    assign m_axis_tdata = {head.overflow, head.value, head.length, head.start};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with no held item");

    a_eof_closes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_EOF) |->
            (m_axis_tlast && m_axis_tdata[31:16] == 16'd0))
        else $error("end-of-file token not last or has nonzero length");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= KIND_LAST))
        else $error("token kind out of range");

    a_value_only_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_NUMBER) |->
            (m_axis_tdata[63:32] == 32'd0))
        else $error("value or overflow set on a non-number token");

endmodule
